@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/vra_pkg.sv @@
// Types, constants and codes shared by the virtual region allocator modules.
package vra_pkg;

  // Sizing of the pool pages and the region table.
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int MAX_REGIONS = 512;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = IDX_W + 1;

  // Field widths.
  localparam int ADDR_W    = 32;
  localparam int PAGES_W   = 21;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int ALU_W     = ADDR_W + 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [ALU_W-1:0] PAGE_MASK = ALU_W'(PAGE_BYTES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_OUTSIDE  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 1'd0,
    CFG_POOL_SIZE = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_SIZE,
    S_ALLOC_FIT,
    S_ALLOC_PLACE,
    S_ALLOC_USED,
    S_REL_SCAN,
    S_REL_SHIFT,
    S_REL_USED,
    S_CHK_LO,
    S_CHK_HI,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   region_address;
    logic [PAGES_W-1:0]  page_count;
  } result_t;

  // One row of the region table.
  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [PAGES_W-1:0] pages;
  } entry_t;

  // Table port driven by the sequencer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_port_t;

  // Operands of the shared adder and comparator.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             gt;
    logic             eq;
  } alu_rsp_t;

endpackage

@@ sv/virtual_region_allocator_unit.sv @@
// Top level of the virtual region allocator: configuration registers and datapath wiring.
//
// Usage:
// - A command beat is taken at a rising edge with start high and busy low.
//   busy stays high until the result has been shown.
// - Each command gives one result beat: done is high for exactly one cycle
//   with result valid; the receiver cannot stall, so it must take it then.
// - Configuration: cfg_we with cfg_index 0 writes the pool base (this also
//   moves the table page), index 1 the pool size. Write only while idle.
// - Allocate steps through the size, fit, place and used-page states, and
//   stops after the size state when the table is full or after the fit
//   state without space; check uses a low and a high compare; release makes
//   one table read per entry in the search and again in the compaction sweep.
// - Allocate and check cost a few passes through the one shared 34-bit
//   adder/comparator; a new command is taken the cycle after done.
// - Reset leaves one region (the table page), one used page and a zero pool.
//   The table memory needs no clearing pass.
module virtual_region_allocator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  vra_pkg::request_t                 request,
  output logic                              busy,
  output logic                              done,
  output vra_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [vra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vra_pkg::CFG_W-1:0]         cfg_data
);

  logic [vra_pkg::ADDR_W-1:0] pool_base;
  logic [vra_pkg::ADDR_W-1:0] pool_size;

  vra_pkg::tbl_port_t tbl;
  vra_pkg::entry_t    rdata;
  vra_pkg::alu_req_t  alu;
  vra_pkg::alu_rsp_t  rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vra_pkg::CFG_POOL_BASE: pool_base <= cfg_data[vra_pkg::ADDR_W-1:0];
        vra_pkg::CFG_POOL_SIZE: pool_size <= cfg_data[vra_pkg::ADDR_W-1:0];
        default:                pool_size <= pool_size;
      endcase
    end
  end

  vra_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .pool_base (pool_base),
    .pool_size (pool_size),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .tbl       (tbl),
    .rdata     (rdata),
    .alu       (alu),
    .rsp       (rsp)
  );

  vra_table u_table (
    .clk   (clk),
    .port  (tbl),
    .rdata (rdata)
  );

  vra_alu u_alu (
    .req (alu),
    .rsp (rsp)
  );

endmodule

@@ sv/vra_alu.sv @@
// Shared adder/subtractor with a magnitude and equality compare on its sum.
module vra_alu (
  input  vra_pkg::alu_req_t req,
  output vra_pkg::alu_rsp_t rsp
);

  logic [vra_pkg::ALU_W-1:0] b_eff;

  // Subtraction is an add of the inverted operand plus one.
  assign b_eff   = req.sub ? ~req.b : req.b;
  assign rsp.sum = req.a + b_eff + vra_pkg::ALU_W'(req.sub);

  // Both compares look at the sum against the third operand.
  assign rsp.gt = rsp.sum > req.c;
  assign rsp.eq = rsp.sum == req.c;

endmodule

@@ sv/vra_table.sv @@
// Region table memory: one write port and one registered read port.
module vra_table (
  input  logic               clk,
  input  vra_pkg::tbl_port_t port,
  output vra_pkg::entry_t    rdata
);

  vra_pkg::entry_t mem [vra_pkg::MAX_REGIONS];

  // Write and registered read; the sequencer never writes entry 0 and ignores its read data.
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rdata <= mem[port.raddr];
  end

endmodule

@@ sv/vra_seq.sv @@
// Sequencer that steps each command through the shared unit and the table.
module vra_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  vra_pkg::request_t             request,
  input  logic [vra_pkg::ADDR_W-1:0]    pool_base,
  input  logic [vra_pkg::ADDR_W-1:0]    pool_size,
  output logic                          busy,
  output logic                          done,
  output vra_pkg::result_t              result,
  output vra_pkg::tbl_port_t            tbl,
  input  vra_pkg::entry_t               rdata,
  output vra_pkg::alu_req_t             alu,
  input  vra_pkg::alu_rsp_t             rsp
);

  vra_pkg::state_t state;
  vra_pkg::state_t state_next;

  logic [vra_pkg::ADDR_W-1:0]  size_r;
  logic [vra_pkg::ADDR_W-1:0]  addr_r;
  logic [vra_pkg::CNT_W-1:0]   count;
  logic [vra_pkg::PAGES_W-1:0] used;
  logic [vra_pkg::PAGES_W-1:0] pages;
  logic [vra_pkg::ADDR_W-1:0]  start_r;
  logic [vra_pkg::CNT_W-1:0]   idx;
  logic [vra_pkg::IDX_W-1:0]   pidx;
  logic                        pend;
  logic [vra_pkg::IDX_W-1:0]   hit;
  logic [vra_pkg::PAGES_W-1:0] hit_pages;
  logic                        found;
  logic                        lo_fail;

  logic                        table_full;
  logic                        no_space;
  logic                        sweep_end;
  logic                        sweep_issue;
  logic [vra_pkg::CNT_W-1:0]   last_idx;
  logic [vra_pkg::ADDR_W-1:0]  last_start;
  logic [vra_pkg::PAGES_W-1:0] last_pages;

  // Shared decodes.
  assign table_full  = count == vra_pkg::CNT_W'(vra_pkg::MAX_REGIONS);
  assign no_space    = (pages != '0) && rsp.gt;
  assign sweep_issue = idx < count;
  assign sweep_end   = !sweep_issue && !pend;
  assign last_idx    = count - vra_pkg::CNT_W'(1);

  // Entry 0 is the table page itself and always sits at the pool base.
  assign last_start = (last_idx == '0) ? pool_base : rdata.start;
  assign last_pages = (last_idx == '0) ? vra_pkg::PAGES_W'(1) : rdata.pages;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      vra_pkg::S_IDLE: begin
        if (start) begin
          case (request.command)
            vra_pkg::CMD_ALLOC:   state_next = vra_pkg::S_ALLOC_SIZE;
            vra_pkg::CMD_RELEASE: state_next = vra_pkg::S_REL_SCAN;
            default:              state_next = vra_pkg::S_CHK_LO;
          endcase
        end
      end
      vra_pkg::S_ALLOC_SIZE: begin
        state_next = table_full ? vra_pkg::S_DONE : vra_pkg::S_ALLOC_FIT;
      end
      vra_pkg::S_ALLOC_FIT: begin
        state_next = no_space ? vra_pkg::S_DONE : vra_pkg::S_ALLOC_PLACE;
      end
      vra_pkg::S_ALLOC_PLACE: state_next = vra_pkg::S_ALLOC_USED;
      vra_pkg::S_ALLOC_USED:  state_next = vra_pkg::S_DONE;
      vra_pkg::S_REL_SCAN: begin
        if (sweep_end) begin
          state_next = found ? vra_pkg::S_REL_SHIFT : vra_pkg::S_DONE;
        end
      end
      vra_pkg::S_REL_SHIFT: begin
        if (sweep_end) begin
          state_next = vra_pkg::S_REL_USED;
        end
      end
      vra_pkg::S_REL_USED: state_next = vra_pkg::S_DONE;
      vra_pkg::S_CHK_LO:   state_next = vra_pkg::S_CHK_HI;
      vra_pkg::S_CHK_HI:   state_next = vra_pkg::S_DONE;
      vra_pkg::S_DONE:     state_next = vra_pkg::S_IDLE;
      default:             state_next = vra_pkg::S_IDLE;
    endcase
  end

  // Operands of the shared unit and the table port for each step.
  always_comb begin
    alu       = '0;
    tbl       = '0;
    tbl.raddr = idx[vra_pkg::IDX_W-1:0];
    case (state)
      vra_pkg::S_ALLOC_SIZE: begin
        alu.a     = vra_pkg::ALU_W'(size_r);
        alu.b     = vra_pkg::PAGE_MASK;
        tbl.raddr = last_idx[vra_pkg::IDX_W-1:0];
      end
      vra_pkg::S_ALLOC_FIT: begin
        alu.a     = vra_pkg::ALU_W'(pages) << vra_pkg::PAGE_SHIFT;
        alu.b     = vra_pkg::ALU_W'(used) << vra_pkg::PAGE_SHIFT;
        alu.c     = vra_pkg::ALU_W'(pool_size);
        tbl.raddr = last_idx[vra_pkg::IDX_W-1:0];
      end
      vra_pkg::S_ALLOC_PLACE: begin
        alu.a           = vra_pkg::ALU_W'(last_start);
        alu.b           = vra_pkg::ALU_W'(last_pages) << vra_pkg::PAGE_SHIFT;
        tbl.we          = 1'b1;
        tbl.waddr       = count[vra_pkg::IDX_W-1:0];
        tbl.wdata.start = rsp.sum[vra_pkg::ADDR_W-1:0];
        tbl.wdata.pages = pages;
        tbl.raddr       = last_idx[vra_pkg::IDX_W-1:0];
      end
      vra_pkg::S_ALLOC_USED: begin
        alu.a = vra_pkg::ALU_W'(used);
        alu.b = vra_pkg::ALU_W'(pages);
      end
      vra_pkg::S_REL_SCAN: begin
        alu.a = vra_pkg::ALU_W'(rdata.start);
        alu.c = vra_pkg::ALU_W'(addr_r);
      end
      vra_pkg::S_REL_SHIFT: begin
        // Each entry read last cycle moves down one place.
        tbl.we    = pend;
        tbl.waddr = pidx - vra_pkg::IDX_W'(1);
        tbl.wdata = rdata;
      end
      vra_pkg::S_REL_USED: begin
        alu.a   = vra_pkg::ALU_W'(used);
        alu.b   = vra_pkg::ALU_W'(hit_pages);
        alu.sub = 1'b1;
      end
      vra_pkg::S_CHK_LO: begin
        alu.a = vra_pkg::ALU_W'(pool_base);
        alu.c = vra_pkg::ALU_W'(addr_r);
      end
      vra_pkg::S_CHK_HI: begin
        alu.a = vra_pkg::ALU_W'(pool_base);
        alu.b = vra_pkg::ALU_W'(pool_size);
        alu.c = vra_pkg::ALU_W'(addr_r);
      end
      default: begin
        alu = '0;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy = state != vra_pkg::S_IDLE;
    done = state == vra_pkg::S_DONE;
  end

  // Control state and the sweep counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vra_pkg::S_IDLE;
      count <= vra_pkg::CNT_W'(1);
      used  <= vra_pkg::PAGES_W'(1);
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        vra_pkg::S_IDLE: begin
          pend  <= 1'b0;
          found <= 1'b0;
        end
        vra_pkg::S_ALLOC_PLACE: begin
          count <= count + vra_pkg::CNT_W'(1);
        end
        vra_pkg::S_ALLOC_USED: begin
          used <= rsp.sum[vra_pkg::PAGES_W-1:0];
        end
        vra_pkg::S_REL_SCAN, vra_pkg::S_REL_SHIFT: begin
          pend <= sweep_issue;
          if (state == vra_pkg::S_REL_SCAN && pend && rsp.eq) begin
            found <= 1'b1;
          end
        end
        vra_pkg::S_REL_USED: begin
          count <= count - vra_pkg::CNT_W'(1);
          // The difference saturates at zero.
          used  <= rsp.sum[vra_pkg::ALU_W-1] ? '0 : rsp.sum[vra_pkg::PAGES_W-1:0];
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      vra_pkg::S_IDLE: begin
        size_r <= request.size_bytes;
        addr_r <= request.address;
        idx    <= vra_pkg::CNT_W'(1);
      end
      vra_pkg::S_ALLOC_SIZE: begin
        pages  <= rsp.sum[vra_pkg::PAGE_SHIFT +: vra_pkg::PAGES_W];
        result <= {vra_pkg::ST_FULL, vra_pkg::ADDR_W'(0), vra_pkg::PAGES_W'(0)};
      end
      vra_pkg::S_ALLOC_FIT: begin
        result <= {vra_pkg::ST_NOSPACE, vra_pkg::ADDR_W'(0), vra_pkg::PAGES_W'(0)};
      end
      vra_pkg::S_ALLOC_PLACE: begin
        start_r <= rsp.sum[vra_pkg::ADDR_W-1:0];
      end
      vra_pkg::S_ALLOC_USED: begin
        result <= {vra_pkg::ST_OK, start_r, pages};
      end
      vra_pkg::S_REL_SCAN: begin
        // Later matches overwrite earlier ones, so the last match wins.
        if (pend && rsp.eq) begin
          hit       <= pidx;
          hit_pages <= rdata.pages;
        end
        if (sweep_issue) begin
          pidx <= idx[vra_pkg::IDX_W-1:0];
          idx  <= idx + vra_pkg::CNT_W'(1);
        end else if (!pend) begin
          idx <= vra_pkg::CNT_W'(hit) + vra_pkg::CNT_W'(1);
        end
        result <= {vra_pkg::ST_NOTFOUND, vra_pkg::ADDR_W'(0), vra_pkg::PAGES_W'(0)};
      end
      vra_pkg::S_REL_SHIFT: begin
        if (sweep_issue) begin
          pidx <= idx[vra_pkg::IDX_W-1:0];
          idx  <= idx + vra_pkg::CNT_W'(1);
        end
      end
      vra_pkg::S_REL_USED: begin
        result <= {vra_pkg::ST_OK, addr_r, hit_pages};
      end
      vra_pkg::S_CHK_LO: begin
        lo_fail <= rsp.gt;
      end
      vra_pkg::S_CHK_HI: begin
        if (lo_fail || !(rsp.gt || rsp.eq)) begin
          result <= {vra_pkg::ST_OUTSIDE, vra_pkg::ADDR_W'(0), vra_pkg::PAGES_W'(0)};
        end else begin
          result <= {vra_pkg::ST_OK, vra_pkg::ADDR_W'(0), vra_pkg::PAGES_W'(0)};
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

@@ sv/vra_checker.sv @@
// Port-level checker for the virtual region allocator, bound to the top level.
`include "assert_macros.svh"

module vra_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input vra_pkg::result_t  result
);

  logic fail_beat;
  logic no_region;

  // An accepted command keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A result beat only appears while a command is in flight.
  `ASSERT_IMPLY(a_done_busy, clk, rst, done, busy)

  // The result strobe lasts a single cycle.
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)

  // Failed commands report no region.
  assign fail_beat = done && (result.status != vra_pkg::ST_OK);
  assign no_region = (result.region_address == '0) && (result.page_count == '0);
  `ASSERT_IMPLY(a_fail_zero, clk, rst, fail_beat, no_region)

endmodule

bind virtual_region_allocator_unit vra_checker u_vra_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ tb/vra_result_check.sv @@
// Result checker for the virtual region allocator: predicts each command's result and compares.
module vra_result_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  vra_pkg::request_t             request,
  input  logic                          done,
  input  vra_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [vra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vra_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the pool registers and the region table.
  logic [vra_pkg::ADDR_W-1:0]  pool_base_q;
  logic [vra_pkg::ADDR_W-1:0]  pool_size_q;
  logic [vra_pkg::ADDR_W-1:0]  start_tbl [vra_pkg::MAX_REGIONS];
  logic [vra_pkg::PAGES_W-1:0] pages_tbl [vra_pkg::MAX_REGIONS];
  int unsigned                 region_total;
  logic [vra_pkg::PAGES_W-1:0] pages_in_use;

  // Results predicted for accepted commands, oldest first.
  vra_pkg::result_t pending_results[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one command to the shadow state and returns the result it should give.
  function automatic vra_pkg::result_t predict_result(input vra_pkg::request_t req);
    vra_pkg::result_t            res;
    logic [63:0]                 need_pages;
    logic [63:0]                 used_bytes;
    logic [63:0]                 free_bytes;
    logic [63:0]                 next_start;
    logic [63:0]                 pool_top;
    int unsigned                 hit;
    int unsigned                 last;
    logic [vra_pkg::PAGES_W-1:0] freed;
    bit                          found;
    res = '0;
    res.status = vra_pkg::ST_OK;
    if (req.command == vra_pkg::CMD_ALLOC) begin
      // The table-full test comes before the space test.
      if (region_total >= vra_pkg::MAX_REGIONS) begin
        res.status = vra_pkg::ST_FULL;
      end else begin
        need_pages = (64'(req.size_bytes) + 64'(vra_pkg::PAGE_BYTES - 1)) /
                     64'(vra_pkg::PAGE_BYTES);
        used_bytes = 64'(pages_in_use) * 64'(vra_pkg::PAGE_BYTES);
        free_bytes = (64'(pool_size_q) > used_bytes) ? 64'(pool_size_q) - used_bytes : 64'd0;
        if (need_pages * 64'(vra_pkg::PAGE_BYTES) > free_bytes) begin
          res.status = vra_pkg::ST_NOSPACE;
        end else begin
          // New region goes right after the last one; the start wraps at 32 bits.
          last = region_total - 1;
          next_start = 64'(start_tbl[last]) +
                       64'(pages_tbl[last]) * 64'(vra_pkg::PAGE_BYTES);
          start_tbl[region_total] = next_start[vra_pkg::ADDR_W-1:0];
          pages_tbl[region_total] = need_pages[vra_pkg::PAGES_W-1:0];
          region_total++;
          pages_in_use = pages_in_use + need_pages[vra_pkg::PAGES_W-1:0];
          res.region_address = next_start[vra_pkg::ADDR_W-1:0];
          res.page_count = need_pages[vra_pkg::PAGES_W-1:0];
        end
      end
    end else if (req.command == vra_pkg::CMD_RELEASE) begin
      // The table page is never searched, and the last match wins.
      found = 1'b0;
      hit = 0;
      for (int i = 1; i < region_total; i++) begin
        if (start_tbl[i] == req.address) begin
          hit = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.status = vra_pkg::ST_NOTFOUND;
      end else begin
        freed = pages_tbl[hit];
        for (int i = hit; i + 1 < region_total; i++) begin
          start_tbl[i] = start_tbl[i + 1];
          pages_tbl[i] = pages_tbl[i + 1];
        end
        region_total--;
        pages_in_use = (pages_in_use >= freed) ? pages_in_use - freed : '0;
        res.region_address = req.address;
        res.page_count = freed;
      end
    end else begin
      // Check and the unused fourth code: the pool end is inclusive and does not wrap.
      pool_top = 64'(pool_base_q) + 64'(pool_size_q);
      if (req.address < pool_base_q || 64'(req.address) > pool_top) begin
        res.status = vra_pkg::ST_OUTSIDE;
      end
    end
    return res;
  endfunction

  // Track register writes, compare result beats, and predict accepted command beats.
  always @(posedge clk) begin : watch_beats
    vra_pkg::result_t want;
    if (rst) begin
      pool_base_q = '0;
      pool_size_q = '0;
      start_tbl[0] = '0;
      pages_tbl[0] = vra_pkg::PAGES_W'(1);
      region_total = 1;
      pages_in_use = vra_pkg::PAGES_W'(1);
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == vra_pkg::CFG_POOL_BASE) begin
          pool_base_q = cfg_data;
          start_tbl[0] = cfg_data;
        end else begin
          pool_size_q = cfg_data;
        end
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(result), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
          if (result.region_address !== want.region_address)
            report_mismatch("region_address", 64'(result.region_address),
                            64'(want.region_address));
          if (result.page_count !== want.page_count)
            report_mismatch("page_count", 64'(result.page_count), 64'(want.page_count));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_result(request));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the virtual region allocator: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_LIMIT = 4000;
  // The fourth command code is not in the enum and behaves as check.
  localparam logic [vra_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          done;
  vra_pkg::request_t             request;
  vra_pkg::result_t              result;
  logic                          cfg_we;
  logic [vra_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vra_pkg::CFG_W-1:0]     cfg_data;
  int                            mismatches;
  int                            outstanding;

  int unsigned                   cycle_count = 0;
  bit                            idle_on;
  logic [vra_pkg::ADDR_W-1:0]    cur_base;
  logic [vra_pkg::ADDR_W-1:0]    cur_size;
  // Starts of regions the block has handed out, used to aim release commands.
  logic [vra_pkg::ADDR_W-1:0]    live_starts[$];
  vra_pkg::request_t             issued_q[$];

  virtual_region_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vra_result_check u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("virtual_region_allocator_unit verification failed");
      $finish;
    end
  end

  // Keep the list of live region starts up to date; sampled away from the driving edge.
  always @(negedge clk) begin : track_regions
    vra_pkg::request_t sent;
    if (!rst) begin
      if (done && issued_q.size() != 0) begin
        sent = issued_q.pop_front();
        if (result.status == vra_pkg::ST_OK) begin
          if (sent.command == vra_pkg::CMD_ALLOC) begin
            live_starts.push_back(result.region_address);
          end else if (sent.command == vra_pkg::CMD_RELEASE) begin
            for (int i = 0; i < live_starts.size(); i++) begin
              if (live_starts[i] == sent.address) begin
                live_starts.delete(i);
                break;
              end
            end
          end
        end
      end
      if (start && !busy) issued_q.push_back(request);
    end
  end

  function automatic vra_pkg::request_t make_req(input logic [vra_pkg::CMD_W-1:0] cmd,
                                                 input logic [vra_pkg::ADDR_W-1:0] size,
                                                 input logic [vra_pkg::ADDR_W-1:0] addr);
    vra_pkg::request_t r;
    r.command = cmd;
    r.size_bytes = size;
    r.address = addr;
    return r;
  endfunction

  // Present one command beat and wait until it is taken.
  task automatic issue(input vra_pkg::request_t req);
    while (idle_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
  endtask

  // Wait until every predicted result has come back and the block is idle, or until DRAIN_LIMIT runs out.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((outstanding != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input vra_pkg::cfg_reg_t idx,
                           input logic [vra_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == vra_pkg::CFG_POOL_BASE) cur_base = value;
    else cur_size = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pool(input logic [vra_pkg::ADDR_W-1:0] base,
                          input logic [vra_pkg::ADDR_W-1:0] size);
    settle();
    write_reg(vra_pkg::CFG_POOL_BASE, base);
    write_reg(vra_pkg::CFG_POOL_SIZE, size);
  endtask

  // Sizes cluster on page boundaries; the wide ones mostly fail for lack of space.
  function automatic logic [vra_pkg::ADDR_W-1:0] pick_size(input bit small_only);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return 32'(vra_pkg::PAGE_BYTES) * $urandom_range(1, 4);
    if (r < 35) return 32'(vra_pkg::PAGE_BYTES) * $urandom_range(1, 4) + 1;
    if (small_only || r < 80) return $urandom_range(1, 3 * vra_pkg::PAGE_BYTES);
    if (r < 90) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 2 * vra_pkg::PAGE_BYTES);
  endfunction

  // Mostly live regions, sometimes the table page or an address that matches nothing.
  function automatic logic [vra_pkg::ADDR_W-1:0] pick_release_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (live_starts.size() != 0 && r < 75)
      return live_starts[$urandom_range(live_starts.size() - 1)];
    if (r < 82) return cur_base;
    if (r < 90 && live_starts.size() != 0) return live_starts[0] + 1;
    return $urandom;
  endfunction

  function automatic logic [vra_pkg::ADDR_W-1:0] pick_check_addr();
    case ($urandom_range(5))
      0: return cur_base;
      1: return cur_base - 1;
      2: return cur_base + cur_size;
      3: return cur_base + cur_size + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(input int alloc_pct, input int release_pct, input bit small_only);
    int unsigned                r;
    logic [vra_pkg::CMD_W-1:0]  cmd;
    logic [vra_pkg::ADDR_W-1:0] size;
    logic [vra_pkg::ADDR_W-1:0] addr;
    r = $urandom_range(99);
    if (r < alloc_pct) cmd = vra_pkg::CMD_ALLOC;
    else if (r < alloc_pct + release_pct) cmd = vra_pkg::CMD_RELEASE;
    else if (r < 97) cmd = vra_pkg::CMD_CHECK;
    else cmd = CMD_UNUSED;
    size = (cmd == vra_pkg::CMD_ALLOC) ? pick_size(small_only) : $urandom;
    if (cmd == vra_pkg::CMD_RELEASE) addr = pick_release_addr();
    else if (cmd == vra_pkg::CMD_ALLOC) addr = $urandom;
    else addr = pick_check_addr();
    issue(make_req(cmd, size, addr));
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    cur_base = '0;
    cur_size = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty pool after reset: inclusive end, zero-page region, no space, table page kept.
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'h0));
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'h1));
    issue(make_req(CMD_UNUSED, $urandom, 32'h0));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h0, $urandom));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h1, $urandom));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h0));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h1000));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h1000));

    // Largest pool: biggest request, largest region that fits, duplicate starts.
    set_pool(32'h0, 32'hFFFF_FFFF);
    issue(make_req(vra_pkg::CMD_ALLOC, 32'hFFFF_FFFF, $urandom));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'hFFFF_E000, $urandom));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h1, $urandom));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h0, $urandom));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h0, $urandom));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'hFFFF_F000));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h0000_1000));
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'hFFFF_FFFF));

    // Base near the top: the table page moves and the next start wraps to zero.
    set_pool(32'hFFFF_F000, 32'hFFFF_FFFF);
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'hFFFF_F000));
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h1000, $urandom));
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'hFFFF_EFFF));
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'hFFFF_F000));
    issue(make_req(vra_pkg::CMD_CHECK, $urandom, 32'h0));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h0));

    // Pool smaller than the pages in use: free space counts as zero.
    set_pool(32'hFFFF_F000, 32'h0);
    issue(make_req(vra_pkg::CMD_ALLOC, 32'h0, $urandom));
    issue(make_req(vra_pkg::CMD_RELEASE, $urandom, 32'h0));

    // Small pool where most allocations run out of space.
    set_pool(32'h0040_0000, 32'h0001_0000);
    repeat (25) random_item(50, 30, 1'b0);

    // Random registers, with no idling at all.
    idle_on = 1'b0;
    set_pool($urandom, $urandom);
    repeat (25) random_item(55, 25, 1'b0);
    idle_on = 1'b1;

    // Fill the table, hit the full limit, then release with long searches.
    set_pool(32'hFFFF_0000, 32'hFFFF_FFFF);
    guard = 0;
    while (live_starts.size() < vra_pkg::MAX_REGIONS - 1 && guard < 2000) begin
      random_item(97, 1, 1'b1);
      guard++;
    end
    repeat (6) random_item(100, 0, 1'b1);
    repeat (20) random_item(10, 80, 1'b0);

    // Modest pool at address zero while many regions are still live.
    set_pool(32'h0, 32'h0010_0000);
    repeat (16) random_item(40, 45, 1'b0);

    // Highest base with an empty pool.
    set_pool(32'hFFFF_FFFF, 32'h0);
    repeat (10) random_item(30, 30, 1'b0);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("virtual_region_allocator_unit verification clean");
    end else begin
      $display("virtual_region_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
